[design/prq_pkg.sv]
// Shared types, codes and sizes for the rank-ordered queue.
package prq_pkg;

    localparam int DEPTH  = 64;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int RANK_W = 64;
    localparam int TAG_W  = 32;
    localparam int ACT_W  = 3;
    localparam int STAT_W = 2;
    localparam int OCC_W  = 7;
    localparam int CAP_W  = 7;
    localparam int DATA_W = 32;
    localparam int ADDR_W = 3;

    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    // action codes
    localparam logic [ACT_W-1:0] ACT_ENQ    = 3'd0;
    localparam logic [ACT_W-1:0] ACT_DEQ    = 3'd1;
    localparam logic [ACT_W-1:0] ACT_DEL    = 3'd2;
    localparam logic [ACT_W-1:0] ACT_LOOKUP = 3'd3;
    localparam logic [ACT_W-1:0] ACT_FIRST  = 3'd4;
    localparam logic [ACT_W-1:0] ACT_NEXT   = 3'd5;

    // status codes
    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_MISS  = 2'd2;
    localparam logic [STAT_W-1:0] STAT_END   = 2'd3;

    // register word select (paddr[2])
    localparam logic REG_CAPACITY = 1'b0;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_APPLY
    } state_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_CMP,
        CELL_INSERT,
        CELL_REMOVE
    } cell_op_t;

    typedef struct packed {
        cell_op_t            op;
        logic                all;
        logic [RANK_W-1:0]   key;
        logic [TAG_W-1:0]    tag;
    } cell_cmd_t;

    typedef struct packed {
        logic [RANK_W-1:0]   rank;
        logic [TAG_W-1:0]    tag;
    } slot_t;

    typedef struct packed {
        logic eq;
        logic gt;
        logic sh;
    } cell_flag_t;

endpackage

[design/prq_if.sv]
// Valid/ready channel interfaces for requests and results.
interface prq_in_if import prq_pkg::*;
    ;
    logic               valid;
    logic               ready;
    logic [ACT_W-1:0]   action;
    logic [RANK_W-1:0]  rank_key;
    logic [TAG_W-1:0]   item_tag;

    modport source (output valid, output action, output rank_key, output item_tag,
                    input ready);
    modport sink   (input valid, input action, input rank_key, input item_tag,
                    output ready);
endinterface

interface prq_out_if import prq_pkg::*;
    ;
    logic               valid;
    logic               ready;
    logic [STAT_W-1:0]  status;
    logic [RANK_W-1:0]  out_rank;
    logic [TAG_W-1:0]   out_tag;
    logic [OCC_W-1:0]   occupancy;

    modport source (output valid, output status, output out_rank, output out_tag,
                    output occupancy, input ready);
    modport sink   (input valid, input status, input out_rank, input out_tag,
                    input occupancy, output ready);
endinterface

[design/pifo_rank_queue_core.sv]
// Top level: control, capacity register and result register over the cell chain.
//
//  channel  | dir | transfer when        | payload
//  in_ch    | in  | valid && ready       | action, rank_key, item_tag
//  out_ch   | out | valid && ready       | status, out_rank, out_tag, occupancy
//  apb      | in  | psel&penable&pwrite  | capacity at paddr[2] == 0
//
// Each request goes through accept, compare in every cell, then apply.
// The apply step waits while the previous result is still held in the
// result register, so a stalled sink stalls the chain in place.
// Reset clears the entry count and control; slot contents stay unknown
// and are never read past the entry count. No clearing pass is needed.
module pifo_rank_queue_core import prq_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    prq_in_if.sink              in_ch,
    prq_out_if.source           out_ch,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready
);

    state_t state_reg, state_next;

    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CAP_W-1:0]   cap_reg;
    logic [ACT_W-1:0]   act_reg;
    logic [RANK_W-1:0]  key_reg;
    logic [TAG_W-1:0]   tag_reg;

    logic               out_valid_reg, out_valid_next;
    logic [STAT_W-1:0]  status_reg, status_next;
    logic [RANK_W-1:0]  rank_out_reg, rank_out_next;
    logic [TAG_W-1:0]   tag_out_reg, tag_out_next;
    logic [OCC_W-1:0]   occ_reg, occ_next;

    cell_cmd_t          cmd;
    slot_t              slots [DEPTH];
    cell_flag_t         flags [DEPTH];
    logic [DEPTH-1:0]   live;
    logic [DEPTH-1:0]   first;

    logic               accept;
    logic               apply_go;
    logic [CNT_W-1:0]   limit;
    logic               full;
    logic               empty;
    logic               hit;
    logic [RANK_W-1:0]  hit_rank;
    logic [TAG_W-1:0]   hit_tag;
    logic               nxt_live;
    logic [RANK_W-1:0]  nxt_rank;

    // configuration port
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cap_reg <= CAP_RESET;
        else if (psel && penable && pwrite && paddr[2] == REG_CAPACITY)
            cap_reg <= pwdata[CAP_W-1:0];
    end

    assign prdata = (paddr[2] == REG_CAPACITY) ? DATA_W'(cap_reg) : '0;

    // handshake and control
    assign accept   = in_ch.valid && in_ch.ready;
    assign apply_go = (state_reg == ST_APPLY) && (!out_valid_reg || out_ch.ready);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (in_ch.valid) state_next = ST_CMP;
            ST_CMP:   state_next = ST_APPLY;
            ST_APPLY: if (apply_go) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ch.ready = 1'b0;
        case (state_reg)
            ST_IDLE: in_ch.ready = 1'b1;
            default: in_ch.ready = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_reg <= in_ch.action;
            key_reg <= in_ch.rank_key;
            tag_reg <= in_ch.item_tag;
        end
    end

    assign limit = (32'(cap_reg) < 32'(DEPTH)) ? CNT_W'(cap_reg) : CNT_W'(DEPTH);
    assign full  = (count_reg >= limit);
    assign empty = (count_reg == '0);

    // cell chain
    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            slot_t left_slot;
            slot_t right_slot;
            logic  left_sh;

            assign live[gi] = (CNT_W'(gi) < count_reg);

            if (gi == 0)
            begin : g_head
                assign left_slot = '0;
                assign left_sh   = 1'b0;
                assign first[gi] = flags[gi].eq;
            end
            else
            begin : g_body
                assign left_slot = slots[gi-1];
                assign left_sh   = flags[gi-1].sh;
                // equal ranks sit together, so a match with no match left is the oldest
                assign first[gi] = flags[gi].eq && !flags[gi-1].eq;
            end

            if (gi == DEPTH - 1)
            begin : g_tail
                assign right_slot = '0;
            end
            else
            begin : g_inner
                assign right_slot = slots[gi+1];
            end

            prq_cell u_cell (
                .clk        (clk),
                .cmd        (cmd),
                .live       (live[gi]),
                .left_sh    (left_sh),
                .left_slot  (left_slot),
                .right_slot (right_slot),
                .slot       (slots[gi]),
                .flag       (flags[gi])
            );
        end
    endgenerate

    // gather the oldest match and the slot behind it
    always_comb
    begin
        hit      = 1'b0;
        hit_rank = '0;
        hit_tag  = '0;
        nxt_live = 1'b0;
        nxt_rank = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            hit      = hit | first[i];
            hit_rank = hit_rank | ({RANK_W{first[i]}} & slots[i].rank);
            hit_tag  = hit_tag | ({TAG_W{first[i]}} & slots[i].tag);
        end
        for (int i = 1; i < DEPTH; i++)
        begin
            nxt_live = nxt_live | (first[i-1] & live[i]);
            nxt_rank = nxt_rank | ({RANK_W{first[i-1] & live[i]}} & slots[i].rank);
        end
    end

    // command to the chain and the result of the apply step
    always_comb
    begin
        cmd.op        = CELL_HOLD;
        cmd.all       = 1'b0;
        cmd.key       = key_reg;
        cmd.tag       = tag_reg;
        count_next    = count_reg;
        status_next   = STAT_MISS;
        rank_out_next = '0;
        tag_out_next  = '0;

        if (state_reg == ST_CMP)
            cmd.op = CELL_CMP;

        case (act_reg)
            ACT_ENQ:
            begin
                if (full)
                    status_next = STAT_FULL;
                else
                begin
                    status_next = STAT_OK;
                    count_next  = count_reg + 1'b1;
                    if (apply_go)
                        cmd.op = CELL_INSERT;
                end
            end
            ACT_DEQ:
            begin
                if (!empty)
                begin
                    status_next   = STAT_OK;
                    rank_out_next = slots[0].rank;
                    tag_out_next  = slots[0].tag;
                    count_next    = count_reg - 1'b1;
                    cmd.all       = 1'b1;
                    if (apply_go)
                        cmd.op = CELL_REMOVE;
                end
            end
            ACT_DEL:
            begin
                if (hit)
                begin
                    status_next  = STAT_OK;
                    tag_out_next = hit_tag;
                    count_next   = count_reg - 1'b1;
                    if (apply_go)
                        cmd.op = CELL_REMOVE;
                end
            end
            ACT_LOOKUP:
            begin
                if (hit)
                begin
                    status_next   = STAT_OK;
                    rank_out_next = hit_rank;
                    tag_out_next  = hit_tag;
                end
            end
            ACT_FIRST:
            begin
                if (empty)
                    status_next = STAT_END;
                else
                begin
                    status_next   = STAT_OK;
                    rank_out_next = slots[0].rank;
                end
            end
            ACT_NEXT:
            begin
                if (hit)
                begin
                    if (!nxt_live)
                        status_next = STAT_END;
                    else
                    begin
                        status_next   = STAT_OK;
                        rank_out_next = nxt_rank;
                    end
                end
            end
            default:
            begin
                status_next = STAT_MISS;
            end
        endcase

        occ_next = OCC_W'(count_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (apply_go)
            count_reg <= count_next;
    end

    // result register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (apply_go)
            out_valid_next = 1'b1;
        else if (out_ch.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (apply_go)
        begin
            status_reg   <= status_next;
            rank_out_reg <= rank_out_next;
            tag_out_reg  <= tag_out_next;
            occ_reg      <= occ_next;
        end
    end

    assign out_ch.valid     = out_valid_reg;
    assign out_ch.status    = status_reg;
    assign out_ch.out_rank  = rank_out_reg;
    assign out_ch.out_tag   = tag_out_reg;
    assign out_ch.occupancy = occ_reg;

endmodule

[design/prq_cell.sv]
// One slot of the sorted chain: holds a rank and tag, compares, shifts.
module prq_cell import prq_pkg::*;
(
    input  logic        clk,
    input  cell_cmd_t   cmd,
    input  logic        live,
    input  logic        left_sh,
    input  slot_t       left_slot,
    input  slot_t       right_slot,
    output slot_t       slot,
    output cell_flag_t  flag
);

    slot_t slot_reg, slot_next;
    logic  eq_reg, eq_next;
    logic  gt_reg, gt_next;
    logic  own_sh;

    // this slot moves right on insert: empty, or holds a larger rank
    assign own_sh = !live || gt_reg;

    always_comb
    begin
        slot_next = slot_reg;
        eq_next   = eq_reg;
        gt_next   = gt_reg;
        case (cmd.op)
            CELL_CMP:
            begin
                eq_next = live && (slot_reg.rank == cmd.key);
                gt_next = live && (slot_reg.rank > cmd.key);
            end
            CELL_INSERT:
            begin
                if (own_sh)
                begin
                    if (left_sh)
                        slot_next = left_slot;
                    else
                        slot_next = '{rank: cmd.key, tag: cmd.tag};
                end
            end
            CELL_REMOVE:
            begin
                // close the gap from the removed slot onward
                if (cmd.all || !live || eq_reg || gt_reg)
                    slot_next = right_slot;
            end
            default:
            begin
                slot_next = slot_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
        eq_reg   <= eq_next;
        gt_reg   <= gt_next;
    end

    assign slot    = slot_reg;
    assign flag.eq = eq_reg;
    assign flag.gt = gt_reg;
    assign flag.sh = own_sh;

endmodule

[design/prq_checker.sv]
// Port-level checks for the rank-ordered queue, bound to the top level.
module prq_checker import prq_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_ready,
    input  logic                out_valid,
    input  logic                out_ready,
    input  logic [STAT_W-1:0]   status,
    input  logic [RANK_W-1:0]   out_rank,
    input  logic [TAG_W-1:0]    out_tag,
    input  logic [OCC_W-1:0]    occupancy
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_rank) && $stable(status))
        else $error("result changed while stalled");

    // one request at a time: busy right after a transfer
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request accepted while busy");

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> 32'(occupancy) <= 32'(DEPTH))
        else $error("occupancy beyond depth");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != STAT_OK |-> out_rank == '0 && out_tag == '0)
        else $error("failed request carries data");

endmodule

bind pifo_rank_queue_core prq_checker u_prq_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (out_ch.status),
    .out_rank  (out_ch.out_rank),
    .out_tag   (out_ch.out_tag),
    .occupancy (out_ch.occupancy)
);

[verif/tb.sv]
// Testbench for pifo_rank_queue_core: random and directed requests checked against a shadow queue.
`timescale 1ns / 100ps

module tb import prq_pkg::*;
    ;

    // action codes the block must treat as no-ops
    localparam logic [ACT_W-1:0] ACT_UNDEF_LO = 3'd6;
    localparam logic [ACT_W-1:0] ACT_UNDEF_HI = 3'd7;
    localparam int N_PHASES = 9;

    typedef struct {
        logic [ACT_W-1:0]  action;
        logic [RANK_W-1:0] rank_key;
        logic [TAG_W-1:0]  item_tag;
    } request_t;

    typedef struct {
        logic [STAT_W-1:0] status;
        logic [RANK_W-1:0] out_rank;
        logic [TAG_W-1:0]  out_tag;
        logic [OCC_W-1:0]  occupancy;
    } result_t;

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    prq_in_if  req_ch ();
    prq_out_if res_ch ();

    pifo_rank_queue_core u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (req_ch),
        .out_ch  (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // shadow of the block: sorted slots and the capacity register
    slot_t             held_slots[$];
    logic [CAP_W-1:0]  shadow_cap;

    request_t          request_fifo[$];
    result_t           awaited_results[$];
    logic [RANK_W-1:0] recent_ranks[$];

    request_t          req_now;
    bit                src_busy;
    int                src_wait;
    bit                src_lazy;
    int                snk_wait;
    bit                snk_lazy;

    int                mismatches;
    int                action_seen[8];
    int                status_seen[4];
    int                peak_occ;
    int                cap_writes;

    int                phase_items[N_PHASES] = '{30, 40, 140, 60, 40, 140, 50, 60, 90};
    logic [CAP_W-1:0]  phase_cap[N_PHASES] = '{7'd0, 7'd1, 7'd127, 7'd65, 7'd2, 7'd64,
                                               7'd5, 7'd0, 7'd64};

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Oldest slot holding the rank, or the slot count when none does.
    function automatic int oldest_slot(logic [RANK_W-1:0] key);
        for (int i = 0; i < held_slots.size(); i++)
        begin
            if (held_slots[i].rank == key)
                return i;
            if (held_slots[i].rank > key)
                break;
        end
        return held_slots.size();
    endfunction

    // Apply one request to the shadow queue and return the result it must produce.
    function automatic result_t apply_request(request_t r);
        result_t res;
        slot_t   ns;
        int      lim;
        int      pos;
        res.status   = STAT_MISS;
        res.out_rank = '0;
        res.out_tag  = '0;
        lim = (shadow_cap < DEPTH) ? int'(shadow_cap) : DEPTH;
        case (r.action)
            ACT_ENQ:
            begin
                if (held_slots.size() >= lim)
                    res.status = STAT_FULL;
                else
                begin
                    pos = 0;
                    while (pos < held_slots.size() && held_slots[pos].rank <= r.rank_key)
                        pos++;
                    ns.rank = r.rank_key;
                    ns.tag  = r.item_tag;
                    held_slots.insert(pos, ns);
                    res.status = STAT_OK;
                end
            end
            ACT_DEQ:
            begin
                if (held_slots.size() > 0)
                begin
                    res.out_rank = held_slots[0].rank;
                    res.out_tag  = held_slots[0].tag;
                    held_slots.delete(0);
                    res.status = STAT_OK;
                end
            end
            ACT_DEL:
            begin
                pos = oldest_slot(r.rank_key);
                if (pos < held_slots.size())
                begin
                    res.out_tag = held_slots[pos].tag;
                    held_slots.delete(pos);
                    res.status = STAT_OK;
                end
            end
            ACT_LOOKUP:
            begin
                pos = oldest_slot(r.rank_key);
                if (pos < held_slots.size())
                begin
                    res.out_rank = held_slots[pos].rank;
                    res.out_tag  = held_slots[pos].tag;
                    res.status = STAT_OK;
                end
            end
            ACT_FIRST:
            begin
                if (held_slots.size() == 0)
                    res.status = STAT_END;
                else
                begin
                    res.out_rank = held_slots[0].rank;
                    res.status = STAT_OK;
                end
            end
            ACT_NEXT:
            begin
                pos = oldest_slot(r.rank_key);
                if (pos < held_slots.size())
                begin
                    if (pos + 1 >= held_slots.size())
                        res.status = STAT_END;
                    else
                    begin
                        res.out_rank = held_slots[pos + 1].rank;
                        res.status = STAT_OK;
                    end
                end
            end
            default: ;
        endcase
        res.occupancy = OCC_W'(held_slots.size());
        return res;
    endfunction

    task automatic note_mismatch(string msg);
        $display("[%0t] MISMATCH %s", $time, msg);
        mismatches++;
    endtask

    // Driver: present queued requests, predict each one at its transfer.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid    <= 1'b0;
            req_ch.action   <= ACT_ENQ;
            req_ch.rank_key <= '0;
            req_ch.item_tag <= '0;
            src_busy = 1'b0;
            src_wait = 0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                awaited_results.push_back(apply_request(req_now));
                action_seen[req_now.action]++;
                src_busy = 1'b0;
                src_wait = src_lazy ? $urandom_range(0, 11) : 0;
            end
            if (!src_busy)
            begin
                if (src_wait > 0)
                    src_wait--;
                else if (request_fifo.size() > 0)
                begin
                    req_now = request_fifo.pop_front();
                    req_ch.action   <= req_now.action;
                    req_ch.rank_key <= req_now.rank_key;
                    req_ch.item_tag <= req_now.item_tag;
                    src_busy = 1'b1;
                end
            end
            req_ch.valid <= src_busy;
        end
    end

    // Monitor: compare each result transfer with the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_ch.ready <= 1'b0;
            snk_wait = 0;
        end
        else
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                if (awaited_results.size() == 0)
                    note_mismatch($sformatf("result with nothing awaited: status %0d rank %h",
                                            res_ch.status, res_ch.out_rank));
                else
                begin
                    result_t want;
                    want = awaited_results.pop_front();
                    if (res_ch.status !== want.status)
                        note_mismatch($sformatf("status got %0d want %0d",
                                                res_ch.status, want.status));
                    if (res_ch.out_rank !== want.out_rank)
                        note_mismatch($sformatf("out_rank got %h want %h",
                                                res_ch.out_rank, want.out_rank));
                    if (res_ch.out_tag !== want.out_tag)
                        note_mismatch($sformatf("out_tag got %h want %h",
                                                res_ch.out_tag, want.out_tag));
                    if (res_ch.occupancy !== want.occupancy)
                        note_mismatch($sformatf("occupancy got %0d want %0d",
                                                res_ch.occupancy, want.occupancy));
                    status_seen[want.status]++;
                    if (int'(want.occupancy) > peak_occ)
                        peak_occ = want.occupancy;
                end
                snk_wait = snk_lazy ? $urandom_range(0, 11) : 0;
            end
            else if (snk_wait > 0)
                snk_wait--;
            res_ch.ready <= (snk_wait == 0);
        end
    end

    task automatic queue_request(logic [ACT_W-1:0] act, logic [RANK_W-1:0] key,
                                 logic [TAG_W-1:0] tag);
        request_t r;
        r.action   = act;
        r.rank_key = key;
        r.item_tag = tag;
        request_fifo.push_back(r);
        if (act == ACT_ENQ)
        begin
            recent_ranks.push_back(key);
            if (recent_ranks.size() > 48)
                void'(recent_ranks.pop_front());
        end
    endtask

    // Favor ranks already enqueued and a narrow pool so searches hit and ranks repeat.
    function automatic logic [RANK_W-1:0] draw_rank();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 35 && recent_ranks.size() > 0)
            return recent_ranks[$urandom_range(0, recent_ranks.size() - 1)];
        if (sel < 65)
            return RANK_W'($urandom_range(0, 15));
        if (sel < 69)
            return '0;
        if (sel < 73)
            return '1;
        if (sel < 75)
            return {RANK_W{1'b1}} - 1;
        return {$urandom, $urandom};
    endfunction

    function automatic logic [ACT_W-1:0] draw_action(bit filling);
        int sel;
        sel = $urandom_range(0, 99);
        if (sel >= 98)
            return $urandom_range(0, 1) ? ACT_UNDEF_LO : ACT_UNDEF_HI;
        if (filling)
        begin
            if (sel < 55) return ACT_ENQ;
            if (sel < 65) return ACT_DEQ;
            if (sel < 75) return ACT_DEL;
            if (sel < 83) return ACT_LOOKUP;
            if (sel < 88) return ACT_FIRST;
            return ACT_NEXT;
        end
        if (sel < 15) return ACT_ENQ;
        if (sel < 55) return ACT_DEQ;
        if (sel < 70) return ACT_DEL;
        if (sel < 80) return ACT_LOOKUP;
        if (sel < 85) return ACT_FIRST;
        return ACT_NEXT;
    endfunction

    // Hold until every request is through and every result is back.
    task automatic wait_idle();
        @(negedge clk);
        while (request_fifo.size() > 0 || src_busy || awaited_results.size() > 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_capacity(logic [CAP_W-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_CAPACITY, 2'b00};
        pwdata  <= {$urandom_range(0, 1) ? 25'h1FF_FFFF : 25'h0, value};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        shadow_cap = value;
        cap_writes++;
    endtask

    initial
    begin
        int guard;
        int n;
        logic [RANK_W-1:0] rank_max;
        logic [CAP_W-1:0]  cap;

        rank_max = '1;
        req_ch.valid    = 1'b0;
        req_ch.action   = ACT_ENQ;
        req_ch.rank_key = '0;
        req_ch.item_tag = '0;
        res_ch.ready    = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        rst_n   = 1'b0;
        src_lazy = 1'b1;
        snk_lazy = 1'b1;
        shadow_cap = CAP_RESET;
        mismatches = 0;
        peak_occ = 0;
        cap_writes = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty-queue misses, extreme ranks and tags, repeated ranks.
        @(negedge clk);
        queue_request(ACT_DEQ, '0, '0);
        queue_request(ACT_FIRST, '0, '0);
        queue_request(ACT_DEL, 64'd5, '0);
        queue_request(ACT_LOOKUP, 64'd5, '0);
        queue_request(ACT_NEXT, 64'd5, '0);
        queue_request(ACT_ENQ, rank_max, 32'hFFFF_FFFF);
        queue_request(ACT_ENQ, '0, '0);
        queue_request(ACT_ENQ, 64'd7, 32'hA5A5_0001);
        queue_request(ACT_ENQ, 64'd7, 32'h5A5A_0002);
        queue_request(ACT_ENQ, 64'd7, 32'hC3C3_0003);
        queue_request(ACT_FIRST, '0, '0);
        queue_request(ACT_NEXT, '0, '0);
        queue_request(ACT_NEXT, 64'd7, '0);
        queue_request(ACT_NEXT, rank_max, '0);
        queue_request(ACT_NEXT, 64'd3, '0);
        queue_request(ACT_LOOKUP, 64'd7, '0);
        queue_request(ACT_DEL, 64'd7, '0);
        queue_request(ACT_LOOKUP, 64'd7, '0);
        queue_request(ACT_UNDEF_LO, 64'd7, 32'hFFFF_FFFF);
        queue_request(ACT_UNDEF_HI, rank_max, 32'h1234_5678);
        queue_request(ACT_LOOKUP, rank_max, '0);
        repeat (5) queue_request(ACT_DEQ, '0, '0);
        wait_idle();

        // Random phases, one capacity setting each; fill first, then drain.
        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            cap = phase_cap[ph];
            if (ph == 7)
                cap = CAP_W'($urandom_range(3, 63));
            write_capacity(cap);
            @(negedge clk);
            src_lazy = (ph % 3) == 0;
            snk_lazy = (ph % 3) != 2;
            n = phase_items[ph];
            for (int k = 0; k < n; k++)
                queue_request(draw_action(k < (n * 6) / 10), draw_rank(),
                              ($urandom_range(0, 19) == 0) ? 32'hFFFF_FFFF : $urandom);
            wait_idle();
        end

        guard = 0;
        while (awaited_results.size() > 0 && guard < 5000)
        begin
            @(negedge clk);
            guard++;
        end
        if (awaited_results.size() > 0)
            note_mismatch($sformatf("%0d results never arrived", awaited_results.size()));
        repeat (10) @(negedge clk);

        $display("Covered enq %0d, deq %0d, del %0d, lookup %0d, first %0d, next %0d, undef %0d",
                 action_seen[ACT_ENQ], action_seen[ACT_DEQ], action_seen[ACT_DEL],
                 action_seen[ACT_LOOKUP], action_seen[ACT_FIRST], action_seen[ACT_NEXT],
                 action_seen[ACT_UNDEF_LO] + action_seen[ACT_UNDEF_HI]);
        $display("Statuses ok %0d, full %0d, miss %0d, end %0d; peak occupancy %0d; %0d cap writes",
                 status_seen[STAT_OK], status_seen[STAT_FULL], status_seen[STAT_MISS],
                 status_seen[STAT_END], peak_occ, cap_writes);
        if (mismatches == 0)
            $display("** pifo_rank_queue_core: PASSED **");
        else
            $display("** pifo_rank_queue_core: FAILED **");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("Timeout with %0d results outstanding", awaited_results.size());
        $display("** pifo_rank_queue_core: FAILED **");
        $finish;
    end

endmodule

[sim.f]
design/prq_pkg.sv
design/prq_if.sv
design/prq_cell.sv
design/pifo_rank_queue_core.sv
design/prq_checker.sv
verif/tb.sv
